// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted (active-low reset).
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mct_pkg.sv -----
// Types and constants for the mini C tokenizer.
// No dependencies; imported by mct_result_q and mini_c_tokenizer.
`default_nettype none

package mct_pkg;

  localparam int KEYWORD_MAX_LEN = 6;
  localparam int POSITION_BITS   = 24;

  localparam int PosOutW      = 24;
  localparam int ValueW       = 31;
  localparam int KindW        = 4;
  localparam int ResultQDepth = 4;
  localparam int NumKw        = 4;
  localparam int KwTextLen    = 6;

  localparam logic [ValueW-1:0] ValueMax = '1;

  localparam logic [7:0] ChNul        = 8'h00;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChSemi       = 8'h3B;
  localparam logic [7:0] ChLParen     = 8'h28;
  localparam logic [7:0] ChRParen     = 8'h29;
  localparam logic [7:0] ChLBrack     = 8'h5B;
  localparam logic [7:0] ChRBrack     = 8'h5D;
  localparam logic [7:0] ChLBrace     = 8'h7B;
  localparam logic [7:0] ChRBrace     = 8'h7D;

  typedef enum logic [KindW-1:0] {
    TokInt,
    TokMain,
    TokVoid,
    TokReturn,
    TokEnd,
    TokInvalid,
    TokConst,
    TokIdent,
    TokSemi,
    TokLParen,
    TokRParen,
    TokLBrack,
    TokRBrack,
    TokLBrace,
    TokRBrace
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e            kind;
    logic [ValueW-1:0]    value;
    logic [PosOutW-1:0]   start_pos;
    logic [PosOutW-1:0]   end_pos;
    logic [PosOutW-1:0]   line;
    logic                 last;
  } token_t;

  typedef logic [7:0] kw_text_t [NumKw][KwTextLen];

  // keyword spellings, in token kind order, zero padded
  localparam kw_text_t KwText = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h6D, 8'h61, 8'h69, 8'h6E, 8'h00, 8'h00},  // main
    '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},  // void
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}   // return
  };

  localparam int KwLen [NumKw] = '{3, 4, 4, 6};

endpackage

`default_nettype wire

// ----- rtl/core/mct_result_q.sv -----
// Small token queue between lexer and output channel; uses mct_pkg.
// Takes up to two tokens per cycle, hands out one unless stalled.
`default_nettype none
`include "assert_macros.svh"

module mct_result_q (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      push_cnt_i,
  input  mct_pkg::token_t wr0_i,
  input  mct_pkg::token_t wr1_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mct_pkg::token_t rd_o
);
  import mct_pkg::*;

  localparam int QPtrW = $clog2(ResultQDepth);
  localparam int QCntW = $clog2(ResultQDepth + 1);

  token_t           mem_q [ResultQDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr1;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign full_o      = (count_q > QCntW'(ResultQDepth - 2));
  assign rd_o        = mem_q[rd_ptr_q];
  assign wr_ptr1     = wr_ptr_q + QPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + QPtrW'(pop);
    count_d  = count_q + QCntW'(push_cnt_i) - QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr1] <= wr1_i;
    end
  end

  `ASSERT_RST(a_no_overflow, clk_i, rst_ni, (push_cnt_i != 2'd0) |-> ((QCntW + 1)'(count_q) + (QCntW + 1)'(push_cnt_i) <= (QCntW + 1)'(ResultQDepth) + (QCntW + 1)'(pop)), "token queue overflow")
  `ASSERT_RST(a_drain_empty, clk_i, rst_ni, (pop && count_q == QCntW'(1) && push_cnt_i == 2'd0) |=> !out_valid_o, "queue not empty after last pop")
  `ASSERT_ALW(a_push_cnt, clk_i, push_cnt_i != 2'd3, "more than two tokens pushed in one cycle")

endmodule

`default_nettype wire

// ----- rtl/core/mini_c_tokenizer.sv -----
// Top level of the mini C tokenizer: byte classification, scan state and
// token build. Depends on mct_pkg and mct_result_q.
//
// Usage:
//   Input channel: one source byte per transfer (text_byte_i) with
//   final_byte_i marking the last byte of a text. Output channel: one token
//   per transfer; last_of_run_o flags the last token caused by a byte.
//   Both channels use valid/stall; a transfer happens when valid is high
//   and stall is low.
//   Output: with the queue empty, the first token caused by a byte is
//   visible in the cycle after its transfer and a second one follows once the
//   first is taken. A byte causes zero, one or two tokens.
//   Throughput: one byte per cycle; the scan state updates in the cycle of
//   the transfer and the tokens land in a four-entry queue, which holds
//   off input (in_stall_o) when fewer than two entries are free.
//   Output stall fills the queue and then backs up the input side.
//   Reset: asynchronous, active low; clears the scan state to idle, offset
//   and line to zero and empties the queue. No clearing pass is needed.
//   A final byte flushes any pending word or constant and restarts the
//   offset and line count at zero for the next text.
`default_nettype none
`include "assert_macros.svh"

module mini_c_tokenizer #(
  parameter int KeywordMaxLen = mct_pkg::KEYWORD_MAX_LEN,
  parameter int PositionBits  = mct_pkg::POSITION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           final_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mct_pkg::KindW-1:0]      token_kind_o,
  output logic [mct_pkg::ValueW-1:0]     constant_value_o,
  output logic [mct_pkg::PosOutW-1:0]    start_position_o,
  output logic [mct_pkg::PosOutW-1:0]    end_position_o,
  output logic [mct_pkg::PosOutW-1:0]    line_number_o,
  output logic                           last_of_run_o
);
  import mct_pkg::*;

  localparam int LenW    = $clog2(KeywordMaxLen + 2);
  localparam int LetIdxW = $clog2(KeywordMaxLen);
  localparam int AccExtW = ValueW + 4;

  typedef enum logic [1:0] {
    ModeIdle,
    ModeNum,
    ModeWord
  } mode_e;

  mode_e                   mode_q, mode_n, mode_d;
  logic [PositionBits-1:0] start_q, start_n, start_d;
  logic [PositionBits-1:0] cursor_q, cursor_d, pos_nxt;
  logic [PositionBits-1:0] line_q, line_n, line_d;
  logic [ValueW-1:0]       acc_q, acc_n, acc_d;
  logic [LenW-1:0]         len_q, len_n, len_d;
  logic [7:0]              letters_q [KeywordMaxLen];
  logic [7:0]              letters_d [KeywordMaxLen];

  logic                    accept, is_letter, is_digit, is_word_char, taken;
  logic [AccExtW-1:0]      acc_ext;
  tok_kind_e               word_kind, single_kind;
  logic                    emit_e, emit_s, emit_l;
  token_t                  tok_e, tok_s, tok_l, wr0, wr1, rd_tok;
  logic [1:0]              push_cnt;
  logic                    q_full;
  logic [NumKw-1:0]        kw_hit;
  logic                    fin_acc, restarted;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full;

  assign is_letter    = (text_byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  assign is_digit     = (text_byte_i inside {[8'h30:8'h39]});
  assign is_word_char = is_letter || (text_byte_i == ChUnderscore);
  assign pos_nxt      = (cursor_q == '1) ? cursor_q : cursor_q + PositionBits'(1);

  assign acc_ext = (AccExtW'(acc_q) << 3) + (AccExtW'(acc_q) << 1)
                 + AccExtW'(text_byte_i[3:0]);

  // keyword match on the word as it stands after this byte
  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      kw_hit[k] = (len_n == LenW'(KwLen[k]));
      for (int i = 0; i < KwTextLen; i++) begin
        if (i < KwLen[k] && letters_d[i] != KwText[k][i]) begin
          kw_hit[k] = 1'b0;
        end
      end
    end
    word_kind = TokIdent;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (kw_hit[k]) begin
        word_kind = tok_kind_e'(KindW'(k));
      end
    end
  end

  always_comb begin
    mode_n    = mode_q;
    start_n   = start_q;
    line_n    = line_q;
    acc_n     = acc_q;
    len_n     = len_q;
    letters_d = letters_q;
    taken     = 1'b0;
    emit_s    = 1'b0;
    single_kind = TokInvalid;

    case (mode_q)
      ModeWord: begin
        if (is_word_char) begin
          taken = 1'b1;
          if (len_q < LenW'(KeywordMaxLen)) begin
            letters_d[len_q[LetIdxW-1:0]] = text_byte_i;
          end
          if (len_q <= LenW'(KeywordMaxLen)) begin
            len_n = len_q + LenW'(1);
          end
        end
      end
      ModeNum: begin
        if (is_digit) begin
          taken = 1'b1;
          acc_n = (acc_ext > AccExtW'(ValueMax)) ? ValueMax : acc_ext[ValueW-1:0];
        end
      end
      default: begin
      end
    endcase

    emit_e = (mode_q != ModeIdle) && !taken;

    if (!taken) begin
      mode_n = ModeIdle;
      emit_s = 1'b1;
      case (text_byte_i)
        ChSemi:    single_kind = TokSemi;
        ChLParen:  single_kind = TokLParen;
        ChRParen:  single_kind = TokRParen;
        ChLBrack:  single_kind = TokLBrack;
        ChRBrack:  single_kind = TokRBrack;
        ChLBrace:  single_kind = TokLBrace;
        ChRBrace:  single_kind = TokRBrace;
        ChNul:     single_kind = TokEnd;
        ChSpace:   emit_s = 1'b0;
        ChNewline: begin
          emit_s = 1'b0;
          line_n = (line_q == '1) ? line_q : line_q + PositionBits'(1);
        end
        default: begin
          if (is_digit) begin
            emit_s  = 1'b0;
            mode_n  = ModeNum;
            start_n = cursor_q;
            acc_n   = ValueW'(text_byte_i[3:0]);
          end else if (is_letter) begin
            emit_s       = 1'b0;
            mode_n       = ModeWord;
            start_n      = cursor_q;
            letters_d[0] = text_byte_i;
            len_n        = LenW'(1);
          end
        end
      endcase
    end

    emit_l = final_byte_i && (mode_n != ModeIdle);

    tok_e.kind      = (mode_q == ModeWord) ? word_kind : TokConst;
    tok_e.value     = (mode_q == ModeNum) ? acc_q : '0;
    tok_e.start_pos = PosOutW'(start_q);
    tok_e.end_pos   = PosOutW'(cursor_q);
    tok_e.line      = PosOutW'(line_q);
    tok_e.last      = 1'b0;

    tok_s.kind      = single_kind;
    tok_s.value     = '0;
    tok_s.start_pos = PosOutW'(cursor_q);
    tok_s.end_pos   = PosOutW'(pos_nxt);
    tok_s.line      = PosOutW'(line_n);
    tok_s.last      = 1'b0;

    tok_l.kind      = (mode_n == ModeWord) ? word_kind : TokConst;
    tok_l.value     = (mode_n == ModeNum) ? acc_n : '0;
    tok_l.start_pos = PosOutW'(start_n);
    tok_l.end_pos   = PosOutW'(pos_nxt);
    tok_l.line      = PosOutW'(line_n);
    tok_l.last      = 1'b0;

    // at most two of the three can fire for one byte
    wr0 = emit_e ? tok_e : (emit_s ? tok_s : tok_l);
    wr1 = (emit_e && emit_s) ? tok_s : tok_l;
    push_cnt = 2'(emit_e) + 2'(emit_s) + 2'(emit_l);
    wr0.last = (push_cnt == 2'd1);
    wr1.last = 1'b1;
    if (!accept) begin
      push_cnt = 2'd0;
    end

    mode_d   = mode_q;
    start_d  = start_q;
    cursor_d = cursor_q;
    line_d   = line_q;
    acc_d    = acc_q;
    len_d    = len_q;
    if (accept) begin
      if (final_byte_i) begin
        mode_d   = ModeIdle;
        start_d  = '0;
        cursor_d = '0;
        line_d   = '0;
        acc_d    = '0;
        len_d    = '0;
      end else begin
        mode_d   = mode_n;
        start_d  = start_n;
        cursor_d = pos_nxt;
        line_d   = line_n;
        acc_d    = acc_n;
        len_d    = len_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      start_q  <= '0;
      cursor_q <= '0;
      line_q   <= '0;
      acc_q    <= '0;
      len_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      cursor_q <= cursor_d;
      line_q   <= line_d;
      acc_q    <= acc_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      letters_q <= letters_d;
    end
  end

  mct_result_q u_result_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .wr0_i       (wr0),
    .wr1_i       (wr1),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rd_o        (rd_tok)
  );

  assign token_kind_o     = rd_tok.kind;
  assign constant_value_o = rd_tok.value;
  assign start_position_o = rd_tok.start_pos;
  assign end_position_o   = rd_tok.end_pos;
  assign line_number_o    = rd_tok.line;
  assign last_of_run_o    = rd_tok.last;

  assign fin_acc   = accept && final_byte_i;
  assign restarted = (mode_q == ModeIdle) && (cursor_q == '0) && (line_q == '0);

  `ASSERT_RST(a_final_restarts, clk_i, rst_ni, fin_acc |=> restarted, "scan not restarted")
  `ASSERT_RST(a_two_tokens_max, clk_i, rst_ni, !(emit_e && emit_s && emit_l), "three tokens")
  `ASSERT_RST(a_pending_has_len, clk_i, rst_ni, mode_q == ModeWord |-> len_q != '0, "empty word")

endmodule

`default_nettype wire
